@@ hdl/psdr_pkg.sv @@
// ----------------------------------------------------------------------------
// psdr_pkg: shared types and constants of the pedal scaler
// Widths of the sample, level and message fields, register indexes,
// controller states and the command and status groups between the
// controller and the datapath.
// ----------------------------------------------------------------------------
package psdr_pkg;

	// Field widths
	localparam int SAMPLE_BITS = 10;
	localparam int LEVEL_W     = 5;
	localparam int DB_W        = 8;
	localparam int CTRL_W      = 7;
	localparam int CHAN_W      = 4;
	localparam int CFG_W       = 10;
	localparam int CFG_IDX_W   = 3;

	// Scaled numerator holds (x - lo) * TOP_LEVEL
	localparam int NUM_W = SAMPLE_BITS + LEVEL_W;
	// Counter over the quotient bits of the divider
	localparam int BIT_W = $clog2(LEVEL_W);

	localparam logic [LEVEL_W-1:0] TOP_LEVEL = LEVEL_W'(31);

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_RANGE_LOW  = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_RANGE_HIGH = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] REG_DEADBAND   = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] REG_CONTROLLER = CFG_IDX_W'(3);
	localparam logic [CFG_IDX_W-1:0] REG_CHANNEL    = CFG_IDX_W'(4);

	// Controller states, one-hot
	typedef enum logic [4:0] {
		ST_IDLE   = 5'b00001,
		ST_PREP   = 5'b00010,
		ST_DIV    = 5'b00100,
		ST_DECIDE = 5'b01000,
		ST_EMIT   = 5'b10000
	} state_t;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic load;   // capture the accepted sample
		logic prep;   // clamp, scale and set up the divider
		logic step;   // one divider step
		logic emit;   // load the next message into the output register
	} cmd_t;

	// Status from the datapath to the controller
	typedef struct packed {
		logic div_done;   // the current divider step is the last one
		logic skip;       // nothing to send for this sample
		logic last_msg;   // the next message is the final one
		logic slot_free;  // the output register can take a message
	} sts_t;

endpackage

@@ hdl/pedal_scale_deadband_ramp_top.sv @@
// ----------------------------------------------------------------------------
// pedal_scale_deadband_ramp_top: pedal sample scaler with deadband and ramp
// Scales raw pedal samples to levels 0..31 and sends controller messages.
// ----------------------------------------------------------------------------
// One sample is taken at a time. After a sample is accepted the block clamps
// and scales it, runs the restoring divider (one quotient bit per cycle) and
// makes the deadband decision; a sample that sends nothing then frees the
// input. Each message then leaves at one per cycle while the output is not
// stalled. The final message may still wait in the output register while the
// next sample is accepted. The first sample after reset sends its level as a
// single message; later samples whose change reaches the deadband send every
// level between the last sent one and the new one.
// ----------------------------------------------------------------------------
module pedal_scale_deadband_ramp_top (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_wr_en,
	input  logic [psdr_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [psdr_pkg::CFG_W-1:0]         cfg_wdata,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic [psdr_pkg::SAMPLE_BITS-1:0]   raw_sample,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic [psdr_pkg::LEVEL_W-1:0]       level,
	output logic [psdr_pkg::CTRL_W-1:0]        controller,
	output logic [psdr_pkg::CHAN_W-1:0]        channel,
	output logic                               final_step
);

	psdr_pkg::cmd_t cmd;
	psdr_pkg::sts_t sts;

	// Sequencing
	psdr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	// Arithmetic, state and output register
	psdr_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata),
		.raw_sample (raw_sample),
		.cmd        (cmd),
		.sts        (sts),
		.out_stall  (out_stall),
		.out_valid  (out_valid),
		.level      (level),
		.controller (controller),
		.channel    (channel),
		.final_step (final_step)
	);

	// An accepted request blocks the input until its work is done.
	a_stall_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("input not stalled after a request was accepted");

	// A taken message that is not final is followed at once by the next one.
	a_ramp_continues: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_stall && !final_step) |=> out_valid)
		else $error("ramp message missing after a non-final message");

	// Successive ramp messages move by exactly one level.
	a_ramp_unit_step: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_stall && !final_step) |=>
		((level == ($past(level) + 5'd1)) || (level == ($past(level) - 5'd1))))
		else $error("ramp level did not move by one step");

endmodule

@@ hdl/psdr_ctrl.sv @@
// ----------------------------------------------------------------------------
// psdr_ctrl: sequencing controller of the pedal scaler
// Steps each request through capture, scaling, division, the deadband
// decision and the emission of the message ramp.
// ----------------------------------------------------------------------------
module psdr_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_stall,
	input  psdr_pkg::sts_t  sts,
	output psdr_pkg::cmd_t  cmd
);

	psdr_pkg::state_t state_q, state_nxt;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= psdr_pkg::ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// A new request is taken only when no sample is in work.
	assign in_stall = (state_q != psdr_pkg::ST_IDLE);

	// Next state and commands
	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		case (state_q)
			psdr_pkg::ST_IDLE: begin
				if (in_valid) begin
					cmd.load  = 1'b1;
					state_nxt = psdr_pkg::ST_PREP;
				end
			end
			psdr_pkg::ST_PREP: begin
				cmd.prep  = 1'b1;
				state_nxt = psdr_pkg::ST_DIV;
			end
			psdr_pkg::ST_DIV: begin
				cmd.step = 1'b1;
				if (sts.div_done) begin
					state_nxt = psdr_pkg::ST_DECIDE;
				end
			end
			psdr_pkg::ST_DECIDE: begin
				if (sts.skip) begin
					state_nxt = psdr_pkg::ST_IDLE;
				end else if (sts.slot_free) begin
					cmd.emit  = 1'b1;
					state_nxt = sts.last_msg ? psdr_pkg::ST_IDLE : psdr_pkg::ST_EMIT;
				end
			end
			psdr_pkg::ST_EMIT: begin
				if (sts.slot_free) begin
					cmd.emit = 1'b1;
					if (sts.last_msg) begin
						state_nxt = psdr_pkg::ST_IDLE;
					end
				end
			end
			default: begin
				state_nxt = psdr_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

@@ hdl/psdr_dp.sv @@
// ----------------------------------------------------------------------------
// psdr_dp: datapath of the pedal scaler
// Holds the configuration registers, clamps and scales the sample, divides
// by the window width one quotient bit per cycle, tracks the last sent
// level and drives the output message register.
// ----------------------------------------------------------------------------
module psdr_dp (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_wr_en,
	input  logic [psdr_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [psdr_pkg::CFG_W-1:0]          cfg_wdata,
	input  logic [psdr_pkg::SAMPLE_BITS-1:0]    raw_sample,
	input  psdr_pkg::cmd_t                      cmd,
	output psdr_pkg::sts_t                      sts,
	input  logic                                out_stall,
	output logic                                out_valid,
	output logic [psdr_pkg::LEVEL_W-1:0]        level,
	output logic [psdr_pkg::CTRL_W-1:0]         controller,
	output logic [psdr_pkg::CHAN_W-1:0]         channel,
	output logic                                final_step
);

	// Configuration registers
	logic [psdr_pkg::SAMPLE_BITS-1:0] range_low_q;
	logic [psdr_pkg::SAMPLE_BITS-1:0] range_high_q;
	logic [psdr_pkg::DB_W-1:0]        deadband_q;
	logic [psdr_pkg::CTRL_W-1:0]      controller_q;
	logic [psdr_pkg::CHAN_W-1:0]      channel_q;

	// Working registers
	logic [psdr_pkg::SAMPLE_BITS-1:0] sample_q;
	logic [psdr_pkg::NUM_W-1:0]       rem_q;
	logic [psdr_pkg::SAMPLE_BITS-1:0] den_q;
	logic [psdr_pkg::LEVEL_W-1:0]     quot_q;
	logic [psdr_pkg::BIT_W-1:0]       bit_q;
	logic [psdr_pkg::LEVEL_W-1:0]     last_level_q;
	logic                             has_sent_q;

	// Output message register
	logic                             out_valid_q;
	logic [psdr_pkg::LEVEL_W-1:0]     level_q;
	logic [psdr_pkg::CTRL_W-1:0]      controller_out_q;
	logic [psdr_pkg::CHAN_W-1:0]      channel_out_q;
	logic                             final_q;

	// Combinational values
	logic                             empty_win;
	logic [psdr_pkg::SAMPLE_BITS-1:0] clamped;
	logic [psdr_pkg::SAMPLE_BITS-1:0] offset;
	logic [psdr_pkg::NUM_W-1:0]       scaled;
	logic [psdr_pkg::NUM_W-1:0]       trial;
	logic                             trial_ge;
	logic [psdr_pkg::LEVEL_W-1:0]     diff;
	logic                             going_up;
	logic [psdr_pkg::LEVEL_W-1:0]     next_level;

	// Configuration writes; an unknown index is ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			range_low_q  <= '0;
			range_high_q <= '1;
			deadband_q   <= psdr_pkg::DB_W'(1);
			controller_q <= psdr_pkg::CTRL_W'(7);
			channel_q    <= '0;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				psdr_pkg::REG_RANGE_LOW:  range_low_q  <= cfg_wdata[psdr_pkg::SAMPLE_BITS-1:0];
				psdr_pkg::REG_RANGE_HIGH: range_high_q <= cfg_wdata[psdr_pkg::SAMPLE_BITS-1:0];
				psdr_pkg::REG_DEADBAND:   deadband_q   <= cfg_wdata[psdr_pkg::DB_W-1:0];
				psdr_pkg::REG_CONTROLLER: controller_q <= cfg_wdata[psdr_pkg::CTRL_W-1:0];
				psdr_pkg::REG_CHANNEL:    channel_q    <= cfg_wdata[psdr_pkg::CHAN_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Clamp the sample to the window and scale the offset by the top level.
	always_comb begin
		empty_win = (range_high_q <= range_low_q);
		if (sample_q < range_low_q) begin
			clamped = range_low_q;
		end else if (sample_q > range_high_q) begin
			clamped = range_high_q;
		end else begin
			clamped = sample_q;
		end
		offset = clamped - range_low_q;
		scaled = psdr_pkg::NUM_W'(offset) * psdr_pkg::NUM_W'(psdr_pkg::TOP_LEVEL);
	end

	// One restoring divider step: compare against the shifted divisor.
	always_comb begin
		trial    = psdr_pkg::NUM_W'(den_q) << bit_q;
		trial_ge = (rem_q >= trial);
	end

	// Sample capture and division. An empty window divides zero by one.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			sample_q <= raw_sample;
		end
		if (cmd.prep) begin
			rem_q  <= empty_win ? '0 : scaled;
			den_q  <= empty_win ? psdr_pkg::SAMPLE_BITS'(1) : (range_high_q - range_low_q);
			quot_q <= '0;
			bit_q  <= psdr_pkg::BIT_W'(psdr_pkg::LEVEL_W - 1);
		end else if (cmd.step) begin
			if (trial_ge) begin
				rem_q <= rem_q - trial;
			end
			quot_q <= {quot_q[psdr_pkg::LEVEL_W-2:0], trial_ge};
			bit_q  <= bit_q - psdr_pkg::BIT_W'(1);
		end
	end

	// Deadband decision and the next level of the ramp.
	always_comb begin
		going_up   = (quot_q > last_level_q);
		diff       = going_up ? (quot_q - last_level_q) : (last_level_q - quot_q);
		if (!has_sent_q) begin
			next_level = quot_q;
		end else if (going_up) begin
			next_level = last_level_q + psdr_pkg::LEVEL_W'(1);
		end else begin
			next_level = last_level_q - psdr_pkg::LEVEL_W'(1);
		end
	end

	// Last sent level; it follows every emitted message.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_level_q <= '0;
			has_sent_q   <= 1'b0;
		end else if (cmd.emit) begin
			last_level_q <= next_level;
			has_sent_q   <= 1'b1;
		end
	end

	// Output valid: set when a message is emitted, cleared once it is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output message payload
	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			level_q          <= next_level;
			controller_out_q <= controller_q;
			channel_out_q    <= channel_q;
			final_q          <= (next_level == quot_q);
		end
	end

	// Status towards the controller
	always_comb begin
		sts.div_done  = (bit_q == '0);
		sts.skip      = has_sent_q &&
		                ((psdr_pkg::DB_W'(diff) < deadband_q) || (diff == '0));
		sts.last_msg  = (next_level == quot_q);
		sts.slot_free = !out_valid_q || !out_stall;
	end

	assign out_valid  = out_valid_q;
	assign level      = level_q;
	assign controller = controller_out_q;
	assign channel    = channel_out_q;
	assign final_step = final_q;

endmodule

@@ tb/sv/pedal_scale_deadband_ramp_top_tb.sv @@
// ----------------------------------------------------------------------------
// pedal_scale_deadband_ramp_top_tb: self-checking bench for the pedal scaler
// A directed table covers the first send after reset, full-scale ramps up and
// down, the deadband limits, empty and inverted windows, clamping and ignored
// register indexes. Random phases with fresh register settings follow. Every
// controller message is checked against a predictor kept in step with the
// accepted requests, with random gaps and stalls on both channels.
// ----------------------------------------------------------------------------
module pedal_scale_deadband_ramp_top_tb;

	import psdr_pkg::*;

	localparam int CLK_PERIOD     = 12;
	localparam int RESET_CYCLES   = 6;
	localparam int SETTLE_CYCLES  = 16;
	localparam int TAIL_CYCLES    = 50;
	localparam int HOLD_CYCLES    = 300;
	localparam int TIMEOUT_CYCLES = 3000000;
	localparam int PHASES         = 20;
	localparam int PHASE_SAMPLES  = 25;

	// Register indexes past the last register; writes to them are ignored.
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_FIRST = CFG_IDX_W'(5);
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_LAST  = CFG_IDX_W'(7);

	localparam logic [SAMPLE_BITS-1:0] SAMPLE_MAX = '1;

	typedef struct {
		logic [LEVEL_W-1:0] level;
		logic [CTRL_W-1:0]  controller;
		logic [CHAN_W-1:0]  channel;
		logic               final_step;
	} ctrl_msg_t;

	typedef enum logic {
		ROW_REG,
		ROW_SAMPLE
	} row_kind_t;

	// One row of the directed table. A pinned row carries its own expected
	// outcome: either nothing, or one final message at the given level.
	typedef struct {
		row_kind_t              kind;
		logic [CFG_IDX_W-1:0]   index;
		logic [CFG_W-1:0]       wdata;
		logic [SAMPLE_BITS-1:0] sample;
		logic                   pinned;
		logic                   pin_count;
		logic [LEVEL_W-1:0]     pin_level;
	} table_row_t;

	logic                   clk;
	logic                   arst_n;
	logic                   cfg_wr_en;
	logic [CFG_IDX_W-1:0]   cfg_index;
	logic [CFG_W-1:0]       cfg_wdata;
	logic                   in_valid;
	logic                   in_stall;
	logic [SAMPLE_BITS-1:0] raw_sample;
	logic                   out_valid;
	logic                   out_stall;
	logic [LEVEL_W-1:0]     level;
	logic [CTRL_W-1:0]      controller;
	logic [CHAN_W-1:0]      channel;
	logic                   final_step;

	// Pinned outcome travelling alongside the offered sample.
	logic                   pin_on;
	logic                   pin_count;
	logic [LEVEL_W-1:0]     pin_level;

	// Shadow registers and the scaler state as the block should hold them.
	logic [SAMPLE_BITS-1:0] cfg_low        = '0;
	logic [SAMPLE_BITS-1:0] cfg_high       = SAMPLE_MAX;
	logic [DB_W-1:0]        cfg_deadband   = DB_W'(1);
	logic [CTRL_W-1:0]      cfg_controller = CTRL_W'(7);
	logic [CHAN_W-1:0]      cfg_channel    = '0;
	logic [LEVEL_W-1:0]     sent_level     = '0;
	logic                   sent_any       = 1'b0;

	ctrl_msg_t              pending_msgs[$];
	table_row_t             directed_rows[$];
	int                     error_count = 0;
	logic                   tx_idling   = 1'b1;
	logic                   rx_idling   = 1'b1;
	int                     hold_asked  = 0;
	logic [SAMPLE_BITS-1:0] last_raw    = '0;

	pedal_scale_deadband_ramp_top uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.raw_sample (raw_sample),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.level      (level),
		.controller (controller),
		.channel    (channel),
		.final_step (final_step)
	);

	// Clock generation.
	initial begin
		clk = 1'b0;
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	// Run limit, far above the slowest correct run.
	initial begin
		#(TIMEOUT_CYCLES * CLK_PERIOD);
		$display("*** FAILED ***");
		$finish;
	end

	task automatic report_error(input string msg);
		$display("ERROR at %0t: %s", $realtime, msg);
		error_count++;
	endtask

	function automatic int pick_run_length();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return $urandom_range(1, 3);
		else if (r < 92)
			return $urandom_range(4, 9);
		return $urandom_range(10, 40);
	endfunction

	// Clamp the sample to the window and scale it to a level.
	function automatic logic [LEVEL_W-1:0] scaled_level(input logic [SAMPLE_BITS-1:0] x);
		int unsigned lo, hi, v;
		lo = cfg_low;
		hi = cfg_high;
		v  = x;
		if (hi <= lo)
			return '0;
		if (v < lo)
			v = lo;
		if (v > hi)
			v = hi;
		return LEVEL_W'(((v - lo) * int'(TOP_LEVEL)) / (hi - lo));
	endfunction

	task automatic push_msg(input logic [LEVEL_W-1:0] lvl, input logic last);
		ctrl_msg_t m;
		m.level      = lvl;
		m.controller = cfg_controller;
		m.channel    = cfg_channel;
		m.final_step = last;
		pending_msgs.push_back(m);
	endtask

	// Work out the messages that one accepted sample causes and advance the
	// scaler state.
	task automatic predict_ramp(input logic [SAMPLE_BITS-1:0] x);
		int lvl, prev, diff;
		lvl  = scaled_level(x);
		prev = sent_level;
		if (!sent_any) begin
			push_msg(LEVEL_W'(lvl), 1'b1);
			sent_level = LEVEL_W'(lvl);
			sent_any   = 1'b1;
			return;
		end
		diff = (lvl > prev) ? lvl - prev : prev - lvl;
		if (diff == 0 || diff < int'(cfg_deadband))
			return;
		if (lvl > prev) begin
			for (int v = prev + 1; v <= lvl; v++)
				push_msg(LEVEL_W'(v), v == lvl);
		end else begin
			for (int v = prev - 1; v >= lvl; v--)
				push_msg(LEVEL_W'(v), v == lvl);
		end
		sent_level = LEVEL_W'(lvl);
	endtask

	// Everything is sampled at the rising edge: register writes update the
	// shadow copy, accepted requests feed the predictor, accepted messages
	// are checked against the oldest expectation.
	always @(posedge clk) begin : monitor
		int        n_before;
		ctrl_msg_t want;
		if (arst_n) begin
			if (cfg_wr_en) begin
				case (cfg_index)
					REG_RANGE_LOW:  cfg_low        = cfg_wdata[SAMPLE_BITS-1:0];
					REG_RANGE_HIGH: cfg_high       = cfg_wdata[SAMPLE_BITS-1:0];
					REG_DEADBAND:   cfg_deadband   = cfg_wdata[DB_W-1:0];
					REG_CONTROLLER: cfg_controller = cfg_wdata[CTRL_W-1:0];
					REG_CHANNEL:    cfg_channel    = cfg_wdata[CHAN_W-1:0];
					default: begin
					end
				endcase
			end
			if (in_valid && !in_stall) begin
				n_before = pending_msgs.size();
				predict_ramp(raw_sample);
				if (pin_on) begin
					while (pending_msgs.size() > n_before)
						void'(pending_msgs.pop_back());
					if (pin_count)
						push_msg(pin_level, 1'b1);
				end
			end
			if (out_valid && !out_stall) begin
				if (pending_msgs.size() == 0) begin
					report_error($sformatf("message level %0d with nothing expected", level));
				end else begin
					want = pending_msgs.pop_front();
					if (level !== want.level)
						report_error($sformatf("level got %0d expected %0d",
							level, want.level));
					if (controller !== want.controller)
						report_error($sformatf("controller got %0d expected %0d",
							controller, want.controller));
					if (channel !== want.channel)
						report_error($sformatf("channel got %0d expected %0d",
							channel, want.channel));
					if (final_step !== want.final_step)
						report_error($sformatf("final_step got %0d expected %0d at level %0d",
							final_step, want.final_step, want.level));
				end
			end
		end
	end

	// Receiver: random stall runs, or a long hold-off when one is asked for.
	initial begin : receiver
		int hold_done;
		int n;
		hold_done = 0;
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_asked != hold_done) begin
				hold_done = hold_asked;
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(negedge clk);
				out_stall <= 1'b0;
			end else if (!rx_idling) begin
				out_stall <= 1'b0;
			end else begin
				n = pick_run_length();
				out_stall <= ($urandom_range(0, 99) < 35);
				repeat (n - 1) @(negedge clk);
			end
		end
	end

	// Offer one sample request, after a random gap while idling is on, and hold it until taken.
	// Called and returning at a falling edge.
	task automatic offer_sample(input logic [SAMPLE_BITS-1:0] s, input logic pinned,
			input logic count, input logic [LEVEL_W-1:0] lvl);
		int gap, r;
		gap = 0;
		if (tx_idling) begin
			r = $urandom_range(0, 99);
			if (r >= 90)
				gap = $urandom_range(10, 40);
			else if (r >= 60)
				gap = $urandom_range(1, 3);
		end
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid   <= 1'b1;
		raw_sample <= s;
		pin_on     <= pinned;
		pin_count  <= count;
		pin_level  <= lvl;
		do
			@(posedge clk);
		while (in_stall);
		@(negedge clk);
	endtask

	// Register write: one cycle of write enable, then the enable is low again before returning.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		@(negedge clk);
	endtask

	// Wait for every expected message, then for the block to finish any
	// sample that sends nothing.
	task automatic drain_block();
		while (pending_msgs.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic add_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
		table_row_t row;
		row = '{kind: ROW_REG, index: idx, wdata: data, sample: '0,
			pinned: 1'b0, pin_count: 1'b0, pin_level: '0};
		directed_rows.push_back(row);
	endtask

	task automatic add_sample(input logic [SAMPLE_BITS-1:0] s);
		table_row_t row;
		row = '{kind: ROW_SAMPLE, index: '0, wdata: '0, sample: s,
			pinned: 1'b0, pin_count: 1'b0, pin_level: '0};
		directed_rows.push_back(row);
	endtask

	task automatic add_pinned(input logic [SAMPLE_BITS-1:0] s, input logic count,
			input logic [LEVEL_W-1:0] lvl);
		table_row_t row;
		row = '{kind: ROW_SAMPLE, index: '0, wdata: '0, sample: s,
			pinned: 1'b1, pin_count: count, pin_level: lvl};
		directed_rows.push_back(row);
	endtask

	// Random sample: anywhere, inside the window, close to the last one, or
	// at an edge of the range or of the window.
	function automatic logic [SAMPLE_BITS-1:0] next_sample();
		int r, v;
		r = $urandom_range(0, 99);
		if (r < 40) begin
			v = $urandom_range(0, int'(SAMPLE_MAX));
		end else if (r < 65) begin
			if (cfg_high > cfg_low)
				v = $urandom_range(int'(cfg_low), int'(cfg_high));
			else
				v = $urandom_range(0, int'(SAMPLE_MAX));
		end else if (r < 85) begin
			v = int'(last_raw) + $urandom_range(0, 40) - 20;
			if (v < 0)
				v = 0;
			if (v > int'(SAMPLE_MAX))
				v = SAMPLE_MAX;
		end else begin
			case ($urandom_range(0, 3))
				0: v = 0;
				1: v = SAMPLE_MAX;
				2: v = cfg_low;
				default: v = cfg_high;
			endcase
		end
		last_raw = SAMPLE_BITS'(v);
		return SAMPLE_BITS'(v);
	endfunction

	// Fresh register settings for one random phase, with junk in the data
	// bits above each register's width.
	task automatic random_config(input int phase);
		int r, a, b;
		r = $urandom_range(0, 9);
		a = $urandom_range(0, int'(SAMPLE_MAX));
		b = $urandom_range(0, int'(SAMPLE_MAX));
		if (phase == 3 || r == 0) begin
			a = 0;
			b = SAMPLE_MAX;
		end else if (r == 1) begin
			b = a;
		end else if (r == 2) begin
			if (a < b) begin
				a = a ^ b;
				b = a ^ b;
				a = a ^ b;
			end
		end else if (r == 3) begin
			b = a + $urandom_range(1, 40);
			if (b > int'(SAMPLE_MAX))
				b = SAMPLE_MAX;
		end else if (a > b) begin
			a = a ^ b;
			b = a ^ b;
			a = a ^ b;
		end
		write_reg(REG_RANGE_LOW, CFG_W'(a));
		write_reg(REG_RANGE_HIGH, CFG_W'(b));

		r = $urandom_range(0, 7);
		if (phase == 3)
			a = 1;
		else if (r == 0)
			a = 0;
		else if (r == 1)
			a = 255;
		else if (r == 2)
			a = $urandom_range(6, 254);
		else
			a = $urandom_range(1, 5);
		write_reg(REG_DEADBAND, {2'($urandom), 8'(a)});

		r = $urandom_range(0, 5);
		a = (r == 0) ? 0 : (r == 1) ? 127 : $urandom_range(0, 127);
		write_reg(REG_CONTROLLER, {3'($urandom), 7'(a)});
		r = $urandom_range(0, 5);
		a = (r == 0) ? 0 : (r == 1) ? 15 : $urandom_range(0, 15);
		write_reg(REG_CHANNEL, {6'($urandom), 4'(a)});

		if ($urandom_range(0, 3) == 0)
			write_reg(CFG_IDX_W'($urandom_range(int'(REG_SPARE_FIRST), int'(REG_SPARE_LAST))),
				CFG_W'($urandom));
	endtask

	// Main sequence: reset, directed table, random phases, drain.
	initial begin : stimulus
		table_row_t row;
		arst_n     = 1'b0;
		cfg_wr_en  = 1'b0;
		cfg_index  = '0;
		cfg_wdata  = '0;
		in_valid   = 1'b0;
		raw_sample = '0;
		pin_on     = 1'b0;
		pin_count  = 1'b0;
		pin_level  = '0;

		// First send after reset, then full-scale ramps down and up.
		add_pinned(SAMPLE_MAX, 1'b1, LEVEL_W'(31));
		add_pinned(SAMPLE_MAX, 1'b0, '0);
		add_sample('0);
		add_pinned('0, 1'b0, '0);
		add_sample(SAMPLE_MAX);
		add_sample(SAMPLE_BITS'(512));
		// Zero deadband with the same level sends nothing.
		add_reg(REG_DEADBAND, CFG_W'(0));
		add_pinned(SAMPLE_BITS'(512), 1'b0, '0);
		add_sample(SAMPLE_BITS'(545));
		// Largest deadband holds back every change.
		add_reg(REG_DEADBAND, CFG_W'(255));
		add_pinned('0, 1'b0, '0);
		add_pinned(SAMPLE_MAX, 1'b0, '0);
		add_reg(REG_DEADBAND, CFG_W'(4));
		add_sample(SAMPLE_BITS'(600));
		add_sample(SAMPLE_BITS'(700));
		// Empty window, then an inverted one: the level is forced to zero.
		add_reg(REG_RANGE_LOW, CFG_W'(500));
		add_reg(REG_RANGE_HIGH, CFG_W'(500));
		add_sample(SAMPLE_MAX);
		add_reg(REG_RANGE_LOW, CFG_W'(600));
		add_reg(REG_RANGE_HIGH, CFG_W'(100));
		add_pinned(SAMPLE_BITS'(300), 1'b0, '0);
		// Clamping below and above the window, with the widest message fields.
		add_reg(REG_RANGE_LOW, CFG_W'(100));
		add_reg(REG_RANGE_HIGH, CFG_W'(900));
		add_reg(REG_DEADBAND, CFG_W'(1));
		add_reg(REG_CONTROLLER, CFG_W'(127));
		add_reg(REG_CHANNEL, CFG_W'(15));
		add_pinned(SAMPLE_BITS'(50), 1'b0, '0);
		add_sample(SAMPLE_BITS'(1000));
		add_pinned(SAMPLE_BITS'(900), 1'b0, '0);
		add_sample(SAMPLE_BITS'(100));
		// Writes past the last register change nothing.
		add_reg(REG_SPARE_FIRST, CFG_W'(10'h3FF));
		add_reg(REG_SPARE_LAST, CFG_W'(0));
		add_sample(SAMPLE_BITS'(500));
		add_reg(REG_RANGE_LOW, CFG_W'(0));
		add_reg(REG_RANGE_HIGH, CFG_W'(1023));
		add_reg(REG_CONTROLLER, CFG_W'(0));
		add_reg(REG_CHANNEL, CFG_W'(0));
		add_sample(SAMPLE_BITS'(10'h155));
		add_reg(REG_RANGE_LOW, CFG_W'(1023));
		add_reg(REG_RANGE_HIGH, CFG_W'(0));
		add_sample(SAMPLE_BITS'(10'h2AA));

		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (directed_rows[i]) begin
			row = directed_rows[i];
			if (row.kind == ROW_REG) begin
				// Withdraw the last offer so that the block is idle for the write.
				in_valid <= 1'b0;
				drain_block();
				write_reg(row.index, row.wdata);
			end else begin
				offer_sample(row.sample, row.pinned, row.pin_count, row.pin_level);
			end
		end

		// Random phases; every fifth one runs without idling on either side.
		for (int phase = 0; phase < PHASES; phase++) begin
			in_valid <= 1'b0;
			pin_on   <= 1'b0;
			drain_block();
			random_config(phase);
			tx_idling = (phase % 5 != 2);
			rx_idling <= (phase % 5 != 2);
			if (phase == 3)
				hold_asked <= hold_asked + 1;
			for (int k = 0; k < PHASE_SAMPLES; k++)
				offer_sample(next_sample(), 1'b0, 1'b0, '0);
		end
		in_valid <= 1'b0;

		while (pending_msgs.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (error_count == 0 && pending_msgs.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

@@ pedal_scale_deadband_ramp_top.f @@
hdl/psdr_pkg.sv
hdl/psdr_ctrl.sv
hdl/psdr_dp.sv
hdl/pedal_scale_deadband_ramp_top.sv
tb/sv/pedal_scale_deadband_ramp_top_tb.sv
